>>> rtl/core/wbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbs_pkg
// shared constants and codes for the word-break segmenter
// ----------------------------------------------------------------------------
package wbs_pkg;

   localparam int DICT_WORDS_DEF = 16;
   localparam int WORD_CHARS_DEF = 16;
   localparam int LEN_W          = 7;
   localparam logic [LEN_W-1:0] LEN_MAX = 7'd127;

   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_DICT  = 2'd1,
      KIND_TEXT  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

endpackage

>>> rtl/core/word_break_segmenter.sv
`timescale 1ns / 1ps
// word break segmenter top level
// a text beat is shifted in on accept, then checked against each dictionary word
// in turn through the shared window compare, then posted as a result
// dictionary and clear beats are applied on accept; one item in flight at a time
// synchronous active-high reset empties dictionary and text window
// ----------------------------------------------------------------------------
// word_break_segmenter
// online word-break check over a chain of window cells
// ----------------------------------------------------------------------------
module word_break_segmenter #(
   parameter int DICT_WORDS = wbs_pkg::DICT_WORDS_DEF,
   parameter int WORD_CHARS = wbs_pkg::WORD_CHARS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_symbol,
   input  logic       req_ends_here,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_segmentable,
   output logic       rsp_text_done
);

   localparam int WI_W   = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
   localparam int TOT_W  = $clog2(DICT_WORDS + 1);
   localparam int CI_W   = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
   localparam int LEN_W  = wbs_pkg::LEN_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_POST
   } state_type;

   // dictionary storage: each word's bytes as one row
   logic [8*WORD_CHARS-1:0] row_mem [DICT_WORDS];
   logic [LEN_W-1:0]        len_mem [DICT_WORDS];
   logic                    bad_mem [DICT_WORDS];
   logic [8*WORD_CHARS-1:0] row_rd_ff;
   logic [LEN_W-1:0]        len_rd_ff;
   logic                    bad_rd_ff;
   logic [8*WORD_CHARS-1:0] build_ff;   // word being loaded
   logic [8*WORD_CHARS-1:0] build_in;
   logic                    build_bad_ff;

   logic [TOT_W-1:0] total_ff;
   logic [LEN_W-1:0] chars_ff;
   state_type        state_ff;
   logic [TOT_W-1:0] widx_ff;
   logic             rd_ok_ff;
   logic             hit_ff;
   logic             last_ff;
   logic             rsp_valid_ff, rsp_seg_ff, rsp_done_ff;

   logic accept;
   logic is_clear, is_dict, is_text;
   logic win_clear, win_push;
   logic [7:0] cell_byte [WORD_CHARS];
   logic       cell_reach [WORD_CHARS];
   logic       reach_new;
   // reach[n] newest bit (index 0 of the recurrence) kept apart from the chain
   logic       reach0_ff;
   logic       reach0_in;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign is_clear  = accept && (req_kind == wbs_pkg::KIND_CLEAR);
   assign is_dict   = accept && (req_kind == wbs_pkg::KIND_DICT);
   assign is_text   = accept && (req_kind == wbs_pkg::KIND_TEXT);

   assign win_push  = is_text;
   assign win_clear = is_clear || ((state_ff == ST_POST) && last_ff);
   assign reach_new = (state_ff == ST_POST) ? hit_ff : 1'b0;

   // window chain: cell 0 is newest byte; reach of cell k is reach[n-k-1]
   // after the push, reach[n] is pending until the scan ends
   for (genvar k = 0; k < WORD_CHARS; k++) begin : g_cell
      logic [7:0] prev_b;
      logic       prev_r;
      if (k == 0) begin : g_head
         assign prev_b = req_symbol;
         assign prev_r = reach0_ff;
      end else begin : g_body
         assign prev_b = cell_byte[k-1];
         assign prev_r = cell_reach[k-1];
      end
      wbs_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .clear          (win_clear),
         .push           (win_push),
         .byte_from_prev (prev_b),
         .reach_from_prev(prev_r),
         .reach_clear_val(1'b0),
         .byte_out       (cell_byte[k]),
         .reach_out      (cell_reach[k])
      );
   end

   always_comb begin
      reach0_in = reach0_ff;
      if (win_clear) reach0_in = 1'b1;
      else if (state_ff == ST_POST) reach0_in = reach_new;
   end

   // the window cells hold bytes newest first, the pushed reach is the old
   // newest bit; a separate register also captures a copy of it at push time
   logic chain_reach0_ff;
   always_ff @(posedge clock) begin
      if (reset) chain_reach0_ff <= 1'b0;
      else if (win_clear) chain_reach0_ff <= 1'b0;
      else if (win_push) chain_reach0_ff <= reach0_ff;
   end

   // word check: word byte i against window byte len-1-i, reach[n-len]
   logic word_hit;
   always_comb begin
      logic ok;
      logic rch;
      ok  = 1'b1;
      rch = 1'b0;
      for (int i = 0; i < WORD_CHARS; i++) begin
         if (LEN_W'(i) < len_rd_ff) begin
            if (row_rd_ff[8*i +: 8] != cell_byte[CI_W'(len_rd_ff - LEN_W'(1)
                                                      - LEN_W'(i))])
               ok = 1'b0;
         end
      end
      // reach[n-len]: len 1 -> pre-push newest, else cell len-1 chain
      if (len_rd_ff == LEN_W'(1)) rch = chain_reach0_ff;
      else if (len_rd_ff != '0 && len_rd_ff <= LEN_W'(WORD_CHARS))
         rch = cell_reach[CI_W'(len_rd_ff - LEN_W'(1))];
      word_hit = rd_ok_ff && !bad_rd_ff && len_rd_ff != '0
                 && len_rd_ff <= LEN_W'(WORD_CHARS) && rch && ok;
   end

   // word row with the incoming byte dropped into its slot
   always_comb begin
      build_in = build_ff;
      if (chars_ff < LEN_W'(WORD_CHARS))
         build_in[8*CI_W'(chars_ff) +: 8] = req_symbol;
   end

   // dictionary load
   always_ff @(posedge clock) begin
      if (is_dict && total_ff < TOT_W'(DICT_WORDS)) begin
         build_ff <= build_in;
         if (req_ends_here) begin
            row_mem[WI_W'(total_ff)] <= build_in;
            len_mem[WI_W'(total_ff)] <= (chars_ff < wbs_pkg::LEN_MAX)
                                        ? chars_ff + LEN_W'(1) : chars_ff;
            bad_mem[WI_W'(total_ff)] <= (chars_ff == '0) ? 1'b0
               : (build_bad_ff || chars_ff >= LEN_W'(WORD_CHARS));
         end
         build_bad_ff <= (chars_ff == '0) ? 1'b0
            : (build_bad_ff || chars_ff >= LEN_W'(WORD_CHARS));
      end
      row_rd_ff <= row_mem[WI_W'(widx_ff)];
      len_rd_ff <= len_mem[WI_W'(widx_ff)];
      bad_rd_ff <= bad_mem[WI_W'(widx_ff)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         chars_ff     <= '0;
         state_ff     <= ST_IDLE;
         widx_ff      <= '0;
         rd_ok_ff     <= 1'b0;
         hit_ff       <= 1'b0;
         last_ff      <= 1'b0;
         reach0_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
         rsp_seg_ff   <= 1'b0;
         rsp_done_ff  <= 1'b0;
      end else begin
         reach0_ff <= reach0_in;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (is_clear) begin
            total_ff <= '0;
            chars_ff <= '0;
         end
         if (is_dict && total_ff < TOT_W'(DICT_WORDS)) begin
            if (req_ends_here) begin
               total_ff <= total_ff + TOT_W'(1);
               chars_ff <= '0;
            end else if (chars_ff < wbs_pkg::LEN_MAX) begin
               chars_ff <= chars_ff + LEN_W'(1);
            end
         end
         case (state_ff)
            ST_IDLE: begin
               if (is_text) begin
                  state_ff <= ST_SCAN;
                  widx_ff  <= '0;
                  rd_ok_ff <= 1'b0;
                  hit_ff   <= 1'b0;
                  last_ff  <= req_ends_here;
               end
            end
            ST_SCAN: begin
               // read data for word widx-1 is in the read registers now
               if (word_hit) hit_ff <= 1'b1;
               rd_ok_ff <= widx_ff < total_ff;
               if (widx_ff == TOT_W'(DICT_WORDS)) state_ff <= ST_POST;
               else widx_ff <= widx_ff + TOT_W'(1);
            end
            ST_POST: begin
               rsp_valid_ff <= 1'b1;
               rsp_seg_ff   <= hit_ff || word_hit;
               rsp_done_ff  <= last_ff;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_segmentable = rsp_seg_ff;
   assign rsp_text_done   = rsp_done_ff;

endmodule

>>> rtl/core/wbs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbs_cell
// one window slot: holds a text byte and its reach bit, shifts on push
// ----------------------------------------------------------------------------
module wbs_cell (
   input  logic       clock,
   input  logic       reset,
   input  logic       clear,
   input  logic       push,
   input  logic [7:0] byte_from_prev,
   input  logic       reach_from_prev,
   input  logic       reach_clear_val,
   output logic [7:0] byte_out,
   output logic       reach_out
);

   logic [7:0] byte_ff, byte_in;
   logic       reach_ff, reach_in;

   always_comb begin
      byte_in  = byte_ff;
      reach_in = reach_ff;
      if (clear) begin
         byte_in  = 8'd0;
         reach_in = reach_clear_val;
      end else if (push) begin
         byte_in  = byte_from_prev;
         reach_in = reach_from_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff  <= 8'd0;
         reach_ff <= reach_clear_val;
      end else begin
         byte_ff  <= byte_in;
         reach_ff <= reach_in;
      end
   end

   assign byte_out  = byte_ff;
   assign reach_out = reach_ff;

endmodule
